// ===== rtl/dlrs_pkg.sv =====
package dlrs_pkg;

    typedef enum logic [1:0] {
        MODE_FRAME   = 2'd0,
        MODE_START   = 2'd1,
        MODE_REAPPLY = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_ASPECT_W = 2'd0,
        REG_ASPECT_H = 2'd1,
        REG_LOGICAL_H = 2'd2,
        REG_SETTLE   = 2'd3
    } t_reg;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [32:0] quo;
    } t_div_rsp;

endpackage

// ===== rtl/dlrs_divider.sv =====
module dlrs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dlrs_pkg::t_div_req i_req,
    output dlrs_pkg::t_div_rsp o_rsp
);
    import dlrs_pkg::*;

    logic [32:0] r_num;
    logic [32:0] r_quo;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] trial;
    logic [16:0] shifted;

    assign shifted = {r_rem[15:0], r_num[32]};
    assign trial   = {1'b0, shifted} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_num  <= {1'b0, i_req.num} + {18'd0, i_req.den[15:1]};
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[31:0], 1'b0};
                if (!trial[17]) begin
                    r_rem <= trial[16:0];
                    r_quo <= {r_quo[31:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_quo <= {r_quo[31:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== rtl/display_layout_resize_settler_unit.sv =====
// Flow: frame, start and reapply items run four rounded divisions in turn (S_LW, S_MW,
// S_CW, S_RW), then S_DECIDE and S_FIN decide the result and S_OUT presents it; clear
// items go straight from S_IDLE to S_FIN and S_OUT.
// Throughput: one item at a time; the next item is taken only after the result has been
// accepted, so a stalled result holds off the next item.
// Reset: synchronous active low; registers return to 16, 9, 480 and 150000, state clears.
module display_layout_resize_settler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_window_width,
    input  logic [15:0] i_window_height,
    input  logic        i_window_valid,
    input  logic [15:0] i_pixel_width,
    input  logic [15:0] i_pixel_height,
    input  logic        i_pixel_valid,
    input  logic signed [31:0] i_delta_us,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_layout_changed,
    output logic        o_render_changed,
    output logic [15:0] o_layout_span,
    output logic signed [15:0] o_modern_x,
    output logic [15:0] o_modern_width,
    output logic signed [15:0] o_narrow_x,
    output logic [15:0] o_narrow_span,
    output logic [14:0] o_split_x,
    output logic [15:0] o_surface_width,
    output logic [15:0] o_surface_height,
    output logic [31:0] o_surface_gen,
    output logic        o_accepted,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dlrs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LW   = 9'b000000010,
        S_MW   = 9'b000000100,
        S_CW   = 9'b000001000,
        S_LAY  = 9'b000010000,
        S_RW   = 9'b000100000,
        S_FIN  = 9'b001000000,
        S_OUT  = 9'b010000000,
        S_DECIDE = 9'b100000000
    } t_state;

    t_state r_state;
    logic [15:0] r_asp_w, r_asp_h;
    logic [11:0] r_log_h;
    logic [19:0] r_settle;

    logic r_rdy;
    logic [15:0] r_app_w, r_app_h, r_fw;
    logic [11:0] r_fh;
    logic [15:0] r_mx, r_mw, r_cx, r_cw, r_rw_s, r_rh_s;
    logic [31:0] r_gen, r_seen;
    logic [19:0] r_stable;
    logic [1:0]  r_pend;

    logic [1:0]  r_mode;
    logic [15:0] r_ww, r_wh, r_pw, r_ph;
    logic        r_wv, r_pv;
    logic [31:0] r_delta;

    logic [15:0] r_lw, r_mwn, r_cwn, r_rwn;
    logic        r_lay_ok, r_rw_ok;
    logic [1:0]  r_chg;
    logic        r_acc;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     div_ok;
    logic [15:0] mul_a, mul_b;
    logic [15:0] app_sel_w, app_sel_h;

    dlrs_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign div_ok = (div_rsp.quo != 33'd0) && (div_rsp.quo[32:16] == 17'd0);
    assign pready = 1'b1;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        case (paddr[3:2])
            REG_ASPECT_W:  prdata = {16'd0, r_asp_w};
            REG_ASPECT_H:  prdata = {16'd0, r_asp_h};
            REG_LOGICAL_H: prdata = {20'd0, r_log_h};
            REG_SETTLE:    prdata = {12'd0, r_settle};
            default:       prdata = '0;
        endcase
    end

    logic        pix_same;
    logic [31:0] n_pix;
    logic        dpos;
    assign n_pix    = {r_pw, r_ph};
    assign pix_same = (n_pix == r_seen);
    assign dpos     = (r_delta != 32'd0) && !r_delta[31];

    logic [16:0] diff_m, diff_c, half_m, half_c;
    assign diff_m = {1'b0, r_lw} - {1'b0, r_mwn};
    assign diff_c = {1'b0, r_lw} - {1'b0, r_cwn};
    assign half_m = diff_m + {16'd0, diff_m[16]};
    assign half_c = diff_c + {16'd0, diff_c[16]};

    logic [19:0] rem20, inc20, stable_next;
    assign rem20 = r_settle - r_stable;
    assign inc20 = (r_delta < {12'd0, rem20}) ? r_delta[19:0] : rem20;
    assign stable_next = (dpos && r_stable < r_settle) ? r_stable + inc20 : r_stable;

    assign app_sel_w = (r_mode == MODE_FRAME) ? r_app_w : r_asp_w;
    assign app_sel_h = (r_mode == MODE_FRAME) ? r_app_h : r_asp_h;

    always_comb begin
        div_req = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            S_IDLE: begin
                div_req.start = i_valid && (i_mode != MODE_CLEAR);
                mul_a         = {4'd0, r_log_h};
                mul_b         = i_window_width;
                div_req.den   = (i_window_height == 16'd0) ? 16'd1 : i_window_height;
            end
            S_LW: begin
                div_req.start = div_rsp.done;
                mul_a         = {4'd0, r_log_h};
                mul_b         = app_sel_w;
                div_req.den   = (app_sel_h == 16'd0) ? 16'd1 : app_sel_h;
            end
            S_MW: begin
                div_req.start = div_rsp.done;
                mul_a         = {4'd0, r_log_h};
                mul_b         = 16'd4;
                div_req.den   = 16'd3;
            end
            S_CW: begin
                div_req.start = div_rsp.done;
                mul_a         = r_ph;
                mul_b         = app_sel_w;
                div_req.den   = (app_sel_h == 16'd0) ? 16'd1 : app_sel_h;
            end
            default: ;
        endcase
        div_req.num = {16'd0, mul_a} * {16'd0, mul_b};
    end

    logic lay_good, rw_good, asp_zero, same_asp, lay_upd, rend_upd;
    assign lay_good = r_wv && (r_ww != 16'd0) && (r_wh != 16'd0) && r_lay_ok
                      && (r_log_h != 12'd0);
    assign rw_good  = r_rw_ok && (r_ph != 16'd0) && (app_sel_h != 16'd0)
                      && (app_sel_w != 16'd0);
    assign asp_zero = (r_asp_w == 16'd0) || (r_asp_h == 16'd0);
    assign same_asp = (r_asp_w == r_app_w) && (r_asp_h == r_app_h);
    assign lay_upd  = lay_good && !(r_fw == r_lw && r_fh == r_log_h);
    assign rend_upd = r_pv && pix_same && (stable_next >= r_settle) && rw_good
                      && ({r_rw_s, r_rh_s} != {r_rwn, r_ph});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_asp_w  <= 16'd16;
            r_asp_h  <= 16'd9;
            r_log_h  <= 12'd480;
            r_settle <= 20'd150000;
            r_rdy <= 1'b0; r_app_w <= '0; r_app_h <= '0; r_fw <= '0; r_fh <= '0;
            r_mx <= '0; r_mw <= '0; r_cx <= '0; r_cw <= '0; r_rw_s <= '0; r_rh_s <= '0;
            r_gen <= '0; r_seen <= '0; r_stable <= '0; r_pend <= '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ASPECT_W:  r_asp_w  <= pwdata[15:0];
                    REG_ASPECT_H:  r_asp_h  <= pwdata[15:0];
                    REG_LOGICAL_H: r_log_h  <= pwdata[11:0];
                    REG_SETTLE:    r_settle <= pwdata[19:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_mode <= i_mode; r_ww <= i_window_width; r_wh <= i_window_height;
                    r_wv <= i_window_valid; r_pw <= i_pixel_width; r_ph <= i_pixel_height;
                    r_pv <= i_pixel_valid; r_delta <= i_delta_us;
                    r_chg <= 2'b00; r_acc <= 1'b1;
                    r_state <= (i_mode == MODE_CLEAR) ? S_FIN : S_LW;
                end
                S_LW: if (div_rsp.done) begin
                    r_lw <= div_rsp.quo[15:0]; r_lay_ok <= div_ok; r_state <= S_MW;
                end
                S_MW: if (div_rsp.done) begin
                    r_mwn <= div_rsp.quo[15:0]; r_lay_ok <= r_lay_ok & div_ok;
                    r_state <= S_CW;
                end
                S_CW: if (div_rsp.done) begin
                    r_cwn <= div_rsp.quo[15:0]; r_lay_ok <= r_lay_ok & div_ok;
                    r_state <= S_RW;
                end
                S_RW: if (div_rsp.done) begin
                    r_rwn <= div_rsp.quo[15:0]; r_rw_ok <= div_ok; r_state <= S_DECIDE;
                end
                S_DECIDE: r_state <= S_FIN;
                S_FIN: begin
                    r_state <= S_OUT;
                    case (r_mode)
                        MODE_FRAME: begin
                            r_pend <= 2'b00;
                            r_chg  <= r_pend | (r_rdy ? {rend_upd, lay_upd} : 2'b00);
                            if (r_rdy) begin
                                if (lay_upd) begin
                                    r_fw <= r_lw; r_fh <= r_log_h;
                                    r_mx <= half_m[16:1];
                                    r_mw <= r_mwn;
                                    r_cx <= half_c[16:1];
                                    r_cw <= r_cwn;
                                end
                                if (r_pv) begin
                                    if (!pix_same) begin
                                        r_seen <= n_pix; r_stable <= '0;
                                    end else begin
                                        r_stable <= stable_next;
                                        if (rend_upd) begin
                                            r_rw_s <= r_rwn; r_rh_s <= r_ph;
                                            r_gen <= r_gen + 32'd1;
                                        end
                                    end
                                end
                            end
                        end
                        MODE_START: begin
                            if (r_rdy || asp_zero) begin
                                r_acc <= 1'b0;
                            end else if (!lay_good || !r_pv || !rw_good) begin
                                r_acc <= 1'b0;
                                r_app_w <= '0; r_app_h <= '0; r_fw <= '0; r_fh <= '0;
                                r_mx <= '0; r_mw <= '0; r_cx <= '0; r_cw <= '0;
                                r_rw_s <= '0; r_rh_s <= '0; r_gen <= '0; r_seen <= '0;
                                r_stable <= '0; r_pend <= '0;
                            end else begin
                                r_app_w <= r_asp_w; r_app_h <= r_asp_h;
                                r_fw <= r_lw; r_fh <= r_log_h;
                                r_mx <= half_m[16:1]; r_mw <= r_mwn;
                                r_cx <= half_c[16:1]; r_cw <= r_cwn;
                                r_seen <= n_pix; r_stable <= '0; r_pend <= '0;
                                r_rw_s <= r_rwn; r_rh_s <= r_ph; r_gen <= 32'd1;
                                r_rdy <= 1'b1;
                            end
                        end
                        MODE_REAPPLY: begin
                            if (!r_rdy || asp_zero) begin
                                r_acc <= 1'b0;
                            end else if (!same_asp) begin
                                r_app_w <= r_asp_w; r_app_h <= r_asp_h;
                                if (lay_good) begin
                                    r_fw <= r_lw; r_fh <= r_log_h;
                                    r_mx <= half_m[16:1]; r_mw <= r_mwn;
                                    r_cx <= half_c[16:1]; r_cw <= r_cwn;
                                end
                                if (!lay_good || !r_pv || !rw_good) begin
                                    r_acc <= 1'b0;
                                end else begin
                                    r_seen <= n_pix; r_stable <= '0;
                                    r_rw_s <= r_rwn; r_rh_s <= r_ph;
                                    r_gen <= r_gen + 32'd1; r_pend <= 2'b11;
                                end
                            end
                        end
                        default: begin
                            r_rdy <= 1'b0; r_app_w <= '0; r_app_h <= '0; r_fw <= '0;
                            r_fh <= '0; r_mx <= '0; r_mw <= '0; r_cx <= '0; r_cw <= '0;
                            r_rw_s <= '0; r_rh_s <= '0; r_gen <= '0; r_seen <= '0;
                            r_stable <= '0; r_pend <= '0;
                        end
                    endcase
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_layout_changed    = r_chg[0];
    assign o_render_changed    = r_chg[1];
    assign o_layout_span       = r_fw;
    assign o_modern_x          = r_mx;
    assign o_modern_width      = r_mw;
    assign o_narrow_x          = r_cx;
    assign o_narrow_span       = r_cw;
    assign o_split_x           = r_fw[15:1];
    assign o_surface_width     = r_rw_s;
    assign o_surface_height    = r_rh_s;
    assign o_surface_gen       = r_gen;
    assign o_accepted          = r_acc;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !o_ready)
        else $error("output valid while accepting input");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_rdy |-> r_gen == 32'd0)
        else $error("generation nonzero while not ready");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_rdy |-> r_pend == 2'b00)
        else $error("pending flags set while not ready");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state register not one-hot");

endmodule
